// ===== rtl/brrs_pkg.sv =====
// package for the banked rom read splitter
// holds geometry constants, command and status codes, and payload structs
package brrs_pkg;

    localparam int CHUNK_BYTES = 32;
    localparam int BANK_BYTES  = 16384;
    localparam int MAX_REQUEST = 16384;
    localparam int BANK_SPLIT  = 32;

    localparam int CHUNK_W    = $clog2(CHUNK_BYTES);
    localparam int BANK_W     = $clog2(BANK_BYTES);
    localparam int OFS_W      = 21;
    localparam int SPAN_W     = OFS_W + 1;
    localparam int LEN_W      = 15;
    localparam int BANK_NUM_W = SPAN_W - BANK_W;

    localparam logic [1:0] CMD_READ = 2'd0;
    localparam logic [1:0] CMD_FILL = 2'd1;
    localparam logic [1:0] CMD_NONE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_READY = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG  = 2'd2;

    localparam logic [15:0] ADDR_MODE_REG = 16'h5000;
    localparam logic [15:0] ADDR_BANK_HI  = 16'h4000;
    localparam logic [15:0] ADDR_BANK_LO  = 16'h2000;
    localparam logic [15:0] ADDR_WINDOW   = 16'h4000;

    localparam logic [1:0] SUB_MODE    = 2'd0;
    localparam logic [1:0] SUB_BANK_HI = 2'd1;
    localparam logic [1:0] SUB_BANK_LO = 2'd2;
    localparam logic [1:0] SUB_READ    = 2'd3;

    localparam logic [2:0] STEP_FIRST_BANK = 3'd0;
    localparam logic [2:0] STEP_DIRECT     = 3'd3;
    localparam logic [2:0] STEP_LAST_ONE   = 3'd3;
    localparam logic [2:0] STEP_LAST_TWO   = 3'd7;

    typedef struct packed {
        logic [1:0]       port;
        logic [OFS_W-1:0] start_offset;
        logic [LEN_W-1:0] read_length;
    } req_t;

    typedef struct packed {
        logic [1:0]       port_res;
        logic [1:0]       command_kind;
        logic [15:0]      pak_address;
        logic [LEN_W-1:0] transfer_length;
        logic [7:0]       fill_value;
        logic [LEN_W-1:0] dest_offset;
        logic [1:0]       status;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [1:0]        port;
        logic              single;
        logic [1:0]        status;
        logic [OFS_W-1:0]  pos;
        logic [SPAN_W-1:0] span_end;
    } desc_t;

endpackage

// ===== rtl/brrs_front.sv =====
// request classifier: checks port readiness and length, rounds the span to chunks
// depends on brrs_pkg
module brrs_front
    import brrs_pkg::*;
(
    input  req_t       req,
    input  logic [3:0] ready_mask,
    output desc_t      desc
);

    logic [SPAN_W-1:0] end_sum;

    always_comb
    begin
        end_sum = {1'b0, req.start_offset} + SPAN_W'(req.read_length)
                  + SPAN_W'(CHUNK_BYTES - 1);
        desc.port     = req.port;
        desc.pos      = (req.start_offset >> CHUNK_W) << CHUNK_W;
        desc.span_end = (end_sum >> CHUNK_W) << CHUNK_W;
        desc.single   = 1'b1;
        priority if (!ready_mask[req.port])
        begin
            desc.status = STAT_NOT_READY;
        end
        else if (req.read_length > LEN_W'(MAX_REQUEST))
        begin
            desc.status = STAT_TOO_LONG;
        end
        else if (req.read_length == '0)
        begin
            desc.status = STAT_OK;
        end
        else
        begin
            desc.status = STAT_OK;
            desc.single = 1'b0;
        end
    end

endmodule

// ===== rtl/brrs_desc_queue.sv =====
// two-entry queue of classified requests between the classifier and the sequencer
// depends on brrs_pkg
module brrs_desc_queue
    import brrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_desc,
    output logic  full,
    input  logic  rd_en,
    output desc_t rd_desc,
    output logic  empty
);

    desc_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_desc = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = 2'(cnt_reg + 2'(wr_en) - 2'(rd_en));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

// ===== rtl/brrs_back.sv =====
// command sequencer: walks a classified request one pak bus command per cycle, stalling
// while its two-entry result buffer is full; depends on brrs_pkg
module brrs_back
    import brrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  desc_t q_desc,
    input  logic  q_empty,
    output logic  q_pop,
    input  logic  pop,
    output logic  empty,
    output res_t  out_item
);

    desc_t      cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] step_reg, step_next;

    res_t       buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [BANK_NUM_W-1:0] bank0, bank1, bank;
    logic [SPAN_W-1:0]     next_bound, stop0;
    logic [LEN_W-1:0]      len0, len1;
    logic [BANK_W-1:0]     rd_off;
    logic                  direct, two, region1, is_last, emit, finish, out_acc;
    logic [1:0]            sub;
    logic [2:0]            last_step;
    res_t                  res;

    always_comb
    begin
        bank0      = BANK_NUM_W'(cur_reg.pos >> BANK_W);
        bank1      = bank0 + BANK_NUM_W'(1);
        next_bound = {bank1, {BANK_W{1'b0}}};
        direct     = bank0 == '0;
        two        = cur_reg.span_end > next_bound;
        stop0      = two ? next_bound : cur_reg.span_end;
        len0       = LEN_W'(stop0 - {1'b0, cur_reg.pos});
        len1       = LEN_W'(cur_reg.span_end - next_bound);
        region1    = step_reg[2];
        sub        = step_reg[1:0];
        bank       = region1 ? bank1 : bank0;
        rd_off     = region1 ? '0 : cur_reg.pos[BANK_W-1:0];
        last_step  = two ? STEP_LAST_TWO : STEP_LAST_ONE;
        is_last    = cur_reg.single || (step_reg == last_step);

        res                 = '0;
        res.port_res        = cur_reg.port;
        res.last            = is_last;
        if (cur_reg.single)
        begin
            res.command_kind = CMD_NONE;
            res.status       = cur_reg.status;
        end
        else
        begin
            unique case (sub)
                SUB_MODE:
                begin
                    res.command_kind    = CMD_FILL;
                    res.pak_address     = ADDR_MODE_REG;
                    res.transfer_length = LEN_W'(CHUNK_BYTES);
                end
                SUB_BANK_HI:
                begin
                    res.command_kind    = CMD_FILL;
                    res.pak_address     = ADDR_BANK_HI;
                    res.transfer_length = LEN_W'(CHUNK_BYTES);
                    res.fill_value      = 8'(bank / BANK_SPLIT);
                end
                SUB_BANK_LO:
                begin
                    res.command_kind    = CMD_FILL;
                    res.pak_address     = ADDR_BANK_LO;
                    res.transfer_length = LEN_W'(CHUNK_BYTES);
                    res.fill_value      = 8'(bank % BANK_SPLIT);
                end
                SUB_READ:
                begin
                    res.command_kind    = CMD_READ;
                    res.pak_address     = (direct && !region1) ? 16'(rd_off)
                                                               : (ADDR_WINDOW | 16'(rd_off));
                    res.transfer_length = region1 ? len1 : len0;
                    res.dest_offset     = region1 ? len0 : '0;
                end
            endcase
        end
    end

    always_comb
    begin
        emit    = cur_valid_reg && (cnt_reg != 2'd2);
        finish  = emit && is_last;
        q_pop   = !q_empty && (!cur_valid_reg || finish);
        out_acc = pop && (cnt_reg != 2'd0);

        cur_next       = q_pop ? q_desc : cur_reg;
        cur_valid_next = q_pop ? 1'b1 : (finish ? 1'b0 : cur_valid_reg);
        priority if (q_pop)
        begin
            step_next = (q_desc.pos[OFS_W-1:BANK_W] == '0) ? STEP_DIRECT : STEP_FIRST_BANK;
        end
        else if (emit)
        begin
            step_next = step_reg + 3'd1;
        end
        else
        begin
            step_next = step_reg;
        end

        wr_ptr_next = wr_ptr_reg ^ emit;
        rd_ptr_next = rd_ptr_reg ^ out_acc;
        cnt_next    = 2'(cnt_reg + 2'(emit) - 2'(out_acc));
    end

    assign empty    = cnt_reg == 2'd0;
    assign out_item = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_FIRST_BANK;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== rtl/banked_rom_read_splitter.sv =====
// top level of the banked rom read splitter: classifier, request queue, sequencer
// depends on brrs_pkg, brrs_front, brrs_desc_queue, brrs_back
//
//   channel   handshake            payload     notes
//   request   push / full          in_item     port, start offset, length
//   command   empty / pop          out_item    one pak bus command per beat
//   config    cfg_we               cfg_data    port ready mask, write only
//
// one command beat per cycle while the result buffer has room; a request gives 1, 4, 5
// or 8 beats, holding the sequencer until its last. a push passes the two-entry request
// queue, which lets pushes continue while the sequencer or pop stalls, and the current
// register before the result buffer. reset clears the ready mask and empties both queues.
module banked_rom_read_splitter
    import brrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  req_t       in_item,
    output logic       empty,
    input  logic       pop,
    output res_t       out_item,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data
);

    logic [3:0] ready_mask_reg, ready_mask_next;
    desc_t      f_desc, q_desc;
    logic       q_empty, q_pop;

    assign ready_mask_next = cfg_we ? cfg_data : ready_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_mask_reg <= 4'd0;
        end
        else
        begin
            ready_mask_reg <= ready_mask_next;
        end
    end

    brrs_front u_front (
        .req        (in_item),
        .ready_mask (ready_mask_reg),
        .desc       (f_desc)
    );

    brrs_desc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_desc (f_desc),
        .full    (full),
        .rd_en   (q_pop),
        .rd_desc (q_desc),
        .empty   (q_empty)
    );

    brrs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_desc   (q_desc),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.command_kind == CMD_NONE) |-> out_item.last)
        else $error("idle or error beat without last");

    a_fill_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.command_kind == CMD_FILL) |->
        (out_item.transfer_length == LEN_W'(CHUNK_BYTES) && out_item.dest_offset == '0
         && !out_item.last))
        else $error("malformed fill write beat");

    a_error_no_command: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.status != STAT_OK) |-> out_item.command_kind == CMD_NONE)
        else $error("error status on a bus command");

endmodule
